// ----- design/clsaf_pkg.sv -----
package clsaf_pkg;

  localparam int unsigned WordW = 64;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic [WordW-1:0] uword_t;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_SOLVE = 2'd1,
    ACT_EVAL  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [23:0] func_value;
    logic [22:0]        ref_angle_deg;
    logic               is_inner;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [22:0] angle_out_deg;
    logic        singular;
    logic        fit_valid;
  } out_item_t;

  // Operation codes for the shared multiply/divide unit
  typedef enum logic [0:0] {
    OP_MUL = 1'b0,
    OP_DIV = 1'b1
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  localparam word_t QOne     = 64'sd65536;
  localparam word_t AngleMax = 64'sd5898240;
  localparam logic [39:0] ScaledMax = 40'd1509949440;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_POW_REQ,
    ST_POW_WAIT,
    ST_LD_Y,
    ST_LD_ACC,
    ST_LD_CROSS_REQ,
    ST_LD_CROSS_WAIT,
    ST_EV_REQ,
    ST_EV_WAIT,
    ST_SV_INIT,
    ST_SV_PIVOT,
    ST_SV_SWAP,
    ST_SV_DIV_REQ,
    ST_SV_DIV_WAIT,
    ST_SV_ELIM_REQ,
    ST_SV_ELIM_WAIT,
    ST_SV_DONE,
    ST_OUT
  } state_t;

  function automatic word_t sat_add(word_t a, word_t b);
    logic signed [WordW:0] s;
    s = {a[WordW-1], a} + {b[WordW-1], b};
    if (s[WordW] != s[WordW-1])
      return s[WordW] ? {1'b1, {(WordW-1){1'b0}}} : {1'b0, {(WordW-1){1'b1}}};
    return s[WordW-1:0];
  endfunction

  function automatic word_t sat_sub(word_t a, word_t b);
    logic signed [WordW:0] s;
    s = {a[WordW-1], a} - {b[WordW-1], b};
    if (s[WordW] != s[WordW-1])
      return s[WordW] ? {1'b1, {(WordW-1){1'b0}}} : {1'b0, {(WordW-1){1'b1}}};
    return s[WordW-1:0];
  endfunction

  function automatic uword_t mag_of(word_t v);
    return v[WordW-1] ? uword_t'(-v) : uword_t'(v);
  endfunction

endpackage

// ----- design/clsaf_if.sv -----
interface clsaf_in_if;
  import clsaf_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface clsaf_out_if;
  import clsaf_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/clsaf_alu.sv -----
// Shared Q.16 multiply / divide unit, sign-magnitude.
// Multiply: four 32x32 partial products, one per cycle, then round.
// Divide: restoring, one quotient bit per cycle over 128 bits, then round.
module clsaf_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  clsaf_pkg::alu_ctl_t ctl,
  input  clsaf_pkg::word_t  op_a,
  input  clsaf_pkg::word_t  op_b,
  output logic              done,
  output clsaf_pkg::word_t  res
);
  import clsaf_pkg::*;

  logic        busy_r, busy_nxt;
  alu_op_t     op_r, op_nxt;
  logic        neg_r, neg_nxt;
  uword_t      x_r, x_nxt;
  uword_t      y_r, y_nxt;
  logic [7:0]  cnt_r, cnt_nxt;
  logic [127:0] acc_r, acc_nxt;   // product, or numerator shifting out
  logic [64:0] rem_r, rem_nxt;
  logic [127:0] q_r, q_nxt;
  logic        done_r, done_nxt;
  word_t       res_r, res_nxt;

  logic [63:0] pp;
  logic [31:0] pa, pb;
  logic [127:0] pp_sh;
  logic [127:0] rnd;
  logic [64:0] rem_sh;
  uword_t      rmag, qlo;
  logic        ovf;

  function automatic word_t pack(logic neg, uword_t mag, logic ov);
    if (neg) begin
      if (ov || mag[63]) return {1'b1, 63'd0};
      return word_t'(-mag);
    end
    if (ov || mag[63]) return {1'b0, {63{1'b1}}};
    return word_t'(mag);
  endfunction

  always_comb begin
    pa = cnt_r[1] ? x_r[63:32] : x_r[31:0];
    pb = cnt_r[0] ? y_r[63:32] : y_r[31:0];
    pp = pa * pb;
    pp_sh = 128'(pp) << (7'(cnt_r[1] + cnt_r[0]) * 7'd32);
    rnd = acc_r + 128'h8000;
    rem_sh = {rem_r[63:0], acc_r[127]};
    rmag = '0;
    ovf = 1'b0;
    qlo = q_r[63:0];
    busy_nxt = busy_r;
    op_nxt = op_r;
    neg_nxt = neg_r;
    x_nxt = x_r;
    y_nxt = y_r;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    rem_nxt = rem_r;
    q_nxt = q_r;
    done_nxt = 1'b0;
    res_nxt = res_r;
    if (!busy_r) begin
      if (ctl.start) begin
        busy_nxt = 1'b1;
        op_nxt = ctl.op;
        neg_nxt = op_a[63] ^ op_b[63];
        x_nxt = mag_of(op_a);
        y_nxt = mag_of(op_b);
        cnt_nxt = '0;
        rem_nxt = '0;
        q_nxt = '0;
        acc_nxt = (ctl.op == OP_MUL) ? '0 : {48'd0, mag_of(op_a), 16'd0};
      end
    end else if (op_r == OP_MUL) begin
      if (cnt_r[2]) begin
        rmag = rnd[79:16];
        ovf = |rnd[127:80];
        res_nxt = pack(neg_r, rmag, ovf);
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        acc_nxt = acc_r + pp_sh;
        cnt_nxt = cnt_r + 8'd1;
      end
    end else begin
      if (cnt_r == 8'd128) begin
        if (rem_r[63:0] >= y_r - rem_r[63:0]) begin
          q_nxt = q_r + 128'd1;
        end
        qlo = q_nxt[63:0];
        res_nxt = pack(neg_r, qlo, |q_nxt[127:64]);
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end else begin
        acc_nxt = {acc_r[126:0], 1'b0};
        if (rem_sh >= {1'b0, y_r}) begin
          rem_nxt = rem_sh - {1'b0, y_r};
          q_nxt = {q_r[126:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          q_nxt = {q_r[126:0], 1'b0};
        end
        cnt_nxt = cnt_r + 8'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    op_r <= op_nxt;
    neg_r <= neg_nxt;
    x_r <= x_nxt;
    y_r <= y_nxt;
    cnt_r <= cnt_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    q_r <= q_nxt;
    res_r <= res_nxt;
  end

  assign done = done_r;
  assign res = res_r;
endmodule

// ----- design/cubic_least_squares_angle_fit.sv -----
// Cubic least-squares angle fit. Load items add x^0..x^6 and x^k*y into
// saturating Q.16 moment sums; a solve item runs Gauss-Jordan with partial
// pivoting on the 4x4 normal system and returns a status item; evaluate
// returns the cubic at x clamped to 0..90 degrees; clear zeroes the sums.
// All multiplies and divides go through one shared unit. A load runs six
// powers and then four cross products; an evaluate and a solve also wait
// out any output stall, and a solve is dominated by the 14 pivot-row
// divides; a singular solve ends at the pivot search. Clear and ignored
// items are handled in the idle state. The block takes one item at a time;
// the result sits in an output register.
module cubic_least_squares_angle_fit (
  input  logic         clk,
  input  logic         rst_n,
  clsaf_in_if.sink     in_ch,
  clsaf_out_if.source  out_ch,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  import clsaf_pkg::*;

  state_t      state_r, state_nxt;
  logic [15:0] gain_r;
  in_item_t    item_r, item_nxt;
  word_t       psum_r [7], psum_nxt [7];
  word_t       xsum_r [4], xsum_nxt [4];
  word_t       coef_r [4], coef_nxt [4];
  logic        fit_r, fit_nxt;
  word_t       pw_r [7], pw_nxt [7];
  word_t       y_r, y_nxt;
  word_t       vacc_r, vacc_nxt;
  word_t       m_r [4][5], m_nxt [4][5];
  logic [2:0]  k_r, k_nxt;
  logic [1:0]  c_r, c_nxt;
  logic [1:0]  i_r, i_nxt;
  logic [1:0]  best_r, best_nxt;
  logic [1:0]  j_r, j_nxt;
  logic [2:0]  col_r, col_nxt;
  uword_t      bm_r, bm_nxt;
  word_t       piv_r, piv_nxt;
  word_t       f_r, f_nxt;
  out_item_t   out_r, out_nxt;
  logic        ov_r, ov_nxt;

  alu_ctl_t    actl;
  word_t       aa, ab, ares;
  logic        adone;

  logic [39:0] prod;
  uword_t      cm;

  clsaf_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (actl),
    .op_a  (aa),
    .op_b  (ab),
    .done  (adone),
    .res   (ares)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.data.action)
            ACT_SOLVE: state_nxt = ST_SV_INIT;
            ACT_CLEAR: state_nxt = ST_IDLE;
            default:   state_nxt = in_ch.data.is_inner ? ST_POW_REQ : ST_IDLE;
          endcase
        end
      end
      ST_POW_REQ:  state_nxt = ST_POW_WAIT;
      ST_POW_WAIT: begin
        if (adone) begin
          if (k_r == 3'd5 || (k_r == 3'd2 && item_r.action != ACT_LOAD)) begin
            state_nxt = (item_r.action == ACT_LOAD) ? ST_LD_Y : ST_EV_REQ;
          end else begin
            state_nxt = ST_POW_REQ;
          end
        end
      end
      ST_LD_Y:          state_nxt = ST_LD_ACC;
      ST_LD_ACC:        state_nxt = ST_LD_CROSS_REQ;
      ST_LD_CROSS_REQ:  state_nxt = ST_LD_CROSS_WAIT;
      ST_LD_CROSS_WAIT: begin
        if (adone) state_nxt = (k_r == 3'd3) ? ST_IDLE : ST_LD_CROSS_REQ;
      end
      ST_EV_REQ:  state_nxt = ST_EV_WAIT;
      ST_EV_WAIT: begin
        if (adone) state_nxt = (k_r == 3'd2) ? ST_OUT : ST_EV_REQ;
      end
      ST_SV_INIT:  state_nxt = ST_SV_PIVOT;
      ST_SV_PIVOT: begin
        if (i_r == 2'd3) begin
          if (bm_nxt == '0) state_nxt = ST_OUT;
          else state_nxt = ST_SV_SWAP;
        end
      end
      ST_SV_SWAP:     state_nxt = ST_SV_DIV_REQ;
      ST_SV_DIV_REQ:  state_nxt = ST_SV_DIV_WAIT;
      ST_SV_DIV_WAIT: begin
        if (adone) state_nxt = (col_r == 3'd4) ? ST_SV_ELIM_REQ : ST_SV_DIV_REQ;
      end
      ST_SV_ELIM_REQ:  state_nxt = ST_SV_ELIM_WAIT;
      ST_SV_ELIM_WAIT: begin
        if (adone && col_r == 3'd4) begin
          if (j_r == 2'd3 || (j_r == 2'd2 && c_r == 2'd3)) begin
            state_nxt = (c_r == 2'd3) ? ST_SV_DONE : ST_SV_PIVOT;
          end else begin
            state_nxt = ST_SV_ELIM_REQ;
          end
        end else if (adone) begin
          state_nxt = ST_SV_ELIM_REQ;
        end
      end
      ST_SV_DONE: state_nxt = ST_OUT;
      ST_OUT:     state_nxt = (!ov_r || out_ch.ready) ? ST_IDLE : ST_OUT;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    item_nxt = item_r;
    psum_nxt = psum_r;
    xsum_nxt = xsum_r;
    coef_nxt = coef_r;
    fit_nxt = fit_r;
    pw_nxt = pw_r;
    y_nxt = y_r;
    vacc_nxt = vacc_r;
    m_nxt = m_r;
    k_nxt = k_r;
    c_nxt = c_r;
    i_nxt = i_r;
    best_nxt = best_r;
    j_nxt = j_r;
    col_nxt = col_r;
    bm_nxt = bm_r;
    piv_nxt = piv_r;
    f_nxt = f_r;
    out_nxt = out_r;
    ov_nxt = ov_r;
    actl = '{start: 1'b0, op: OP_MUL};
    aa = '0;
    ab = '0;
    cm = '0;
    prod = 40'(item_r.ref_angle_deg) * (40'd256 + 40'(gain_r));
    in_ch.ready = 1'b0;

    if (ov_r && out_ch.ready) ov_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          item_nxt = in_ch.data;
          pw_nxt[0] = QOne;
          k_nxt = '0;
          if (in_ch.data.action == ACT_CLEAR) begin
            for (int n = 0; n < 7; n++) psum_nxt[n] = '0;
            for (int n = 0; n < 4; n++) xsum_nxt[n] = '0;
          end
        end
      end
      ST_POW_REQ: begin
        actl = '{start: 1'b1, op: OP_MUL};
        aa = pw_r[k_r];
        ab = word_t'(item_r.func_value);
      end
      ST_POW_WAIT: begin
        if (adone) begin
          pw_nxt[k_r + 3'd1] = ares;
          k_nxt = k_r + 3'd1;
          // evaluate needs only x^1..x^3
          if (k_r == 3'd5 || (k_r == 3'd2 && item_r.action != ACT_LOAD)) k_nxt = '0;
        end
      end
      ST_LD_Y: begin
        if (prod > ScaledMax) y_nxt = word_t'(item_r.ref_angle_deg);
        else y_nxt = word_t'((prod + 40'd128) >> 8);
        k_nxt = '0;
      end
      ST_LD_ACC: begin
        for (int n = 0; n < 7; n++) psum_nxt[n] = sat_add(psum_r[n], pw_r[n]);
      end
      ST_LD_CROSS_REQ: begin
        actl = '{start: 1'b1, op: OP_MUL};
        aa = pw_r[k_r];
        ab = y_r;
      end
      ST_LD_CROSS_WAIT: begin
        if (adone) begin
          xsum_nxt[k_r[1:0]] = sat_add(xsum_r[k_r[1:0]], ares);
          k_nxt = k_r + 3'd1;
        end
      end
      ST_EV_REQ: begin
        actl = '{start: 1'b1, op: OP_MUL};
        aa = coef_r[k_r[1:0]];
        ab = pw_r[3'd3 - k_r];
      end
      ST_EV_WAIT: begin
        if (adone) begin
          if (k_r == 3'd0) vacc_nxt = ares;
          else vacc_nxt = sat_add(vacc_r, ares);
          k_nxt = k_r + 3'd1;
          if (k_r == 3'd2) begin
            vacc_nxt = sat_add(sat_add(vacc_r, ares), coef_r[3]);
            out_nxt.result_kind = 1'b1;
            out_nxt.singular = 1'b0;
            out_nxt.fit_valid = fit_r;
            if (vacc_nxt > AngleMax) out_nxt.angle_out_deg = 23'(AngleMax);
            else if (vacc_nxt[63]) out_nxt.angle_out_deg = '0;
            else out_nxt.angle_out_deg = vacc_nxt[22:0];
            ov_nxt = 1'b1;
          end
        end
      end
      ST_SV_INIT: begin
        for (int r = 0; r < 4; r++) begin
          for (int q = 0; q < 4; q++) m_nxt[r][q] = psum_r[6 - r - q];
          m_nxt[r][4] = xsum_r[3 - r];
        end
        c_nxt = '0;
        i_nxt = '0;
        best_nxt = '0;
        bm_nxt = mag_of(psum_r[6]);
      end
      ST_SV_PIVOT: begin
        // scan row c and the rows below it for the largest magnitude, one row a cycle
        if (i_r <= c_r) begin
          best_nxt = c_r;
          bm_nxt = mag_of(m_r[c_r][c_r]);
        end else begin
          cm = mag_of(m_r[i_r][c_r]);
          if (cm > bm_r) begin
            bm_nxt = cm;
            best_nxt = i_r;
          end
        end
        if (i_r != 2'd3) i_nxt = (i_r < c_r) ? c_r : i_r + 2'd1;
        if (i_r == 2'd3 && bm_nxt == '0) begin
          for (int n = 0; n < 4; n++) coef_nxt[n] = '0;
          fit_nxt = 1'b0;
          out_nxt = '{result_kind: 1'b0, angle_out_deg: '0, singular: 1'b1,
                      fit_valid: 1'b0};
          ov_nxt = 1'b1;
        end
      end
      ST_SV_SWAP: begin
        m_nxt[c_r] = m_r[best_r];
        m_nxt[best_r] = m_r[c_r];
        piv_nxt = m_r[best_r][c_r];
        col_nxt = {1'b0, c_r};
      end
      ST_SV_DIV_REQ: begin
        actl = '{start: 1'b1, op: OP_DIV};
        aa = m_r[c_r][col_r];
        ab = piv_r;
      end
      ST_SV_DIV_WAIT: begin
        if (adone) begin
          m_nxt[c_r][col_r] = ares;
          if (col_r == 3'd4) begin
            j_nxt = (c_r == 2'd0) ? 2'd1 : 2'd0;
            f_nxt = (c_r == 2'd0) ? m_r[1][c_r] : m_r[0][c_r];
            col_nxt = {1'b0, c_r};
          end else begin
            col_nxt = col_r + 3'd1;
          end
        end
      end
      ST_SV_ELIM_REQ: begin
        actl = '{start: 1'b1, op: OP_MUL};
        aa = f_r;
        ab = m_r[c_r][col_r];
      end
      ST_SV_ELIM_WAIT: begin
        if (adone) begin
          m_nxt[j_r][col_r] = sat_sub(m_r[j_r][col_r], ares);
          if (col_r == 3'd4) begin
            col_nxt = {1'b0, c_r};
            if (j_r == 2'd3 || (j_r == 2'd2 && c_r == 2'd3)) begin
              c_nxt = c_r + 2'd1;
              i_nxt = '0;
            end else begin
              j_nxt = (j_r + 2'd1 == c_r) ? j_r + 2'd2 : j_r + 2'd1;
              f_nxt = m_r[(j_r + 2'd1 == c_r) ? j_r + 2'd2 : j_r + 2'd1][c_r];
            end
          end else begin
            col_nxt = col_r + 3'd1;
          end
        end
      end
      ST_SV_DONE: begin
        for (int n = 0; n < 4; n++) coef_nxt[n] = m_r[n][4];
        fit_nxt = 1'b1;
        out_nxt = '{result_kind: 1'b0, angle_out_deg: '0, singular: 1'b0,
                    fit_valid: 1'b1};
        ov_nxt = 1'b1;
      end
      ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      gain_r <= 16'd2560;
      fit_r <= 1'b0;
      ov_r <= 1'b0;
      for (int n = 0; n < 7; n++) psum_r[n] <= '0;
      for (int n = 0; n < 4; n++) xsum_r[n] <= '0;
      for (int n = 0; n < 4; n++) coef_r[n] <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) gain_r <= cfg_wdata;
      fit_r <= fit_nxt;
      ov_r <= ov_nxt;
      psum_r <= psum_nxt;
      xsum_r <= xsum_nxt;
      coef_r <= coef_nxt;
    end
    item_r <= item_nxt;
    pw_r <= pw_nxt;
    y_r <= y_nxt;
    vacc_r <= vacc_nxt;
    m_r <= m_nxt;
    k_r <= k_nxt;
    c_r <= c_nxt;
    i_r <= i_nxt;
    best_r <= best_nxt;
    j_r <= j_nxt;
    col_r <= col_nxt;
    bm_r <= bm_nxt;
    piv_r <= piv_nxt;
    f_r <= f_nxt;
    out_r <= out_nxt;
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data = out_r;
endmodule

// ----- bench/cubic_least_squares_angle_fit_tb.sv -----
module cubic_least_squares_angle_fit_tb;
  import clsaf_pkg::*;

  localparam int WatchLimit = 40000;
  localparam int DrainCycles = 300;
  localparam logic signed [63:0] SMax = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] SMin = 64'sh8000_0000_0000_0000;
  localparam logic signed [63:0] NinetyQ = 64'sd5898240;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  clsaf_in_if in_if ();
  clsaf_out_if out_if ();

  cubic_least_squares_angle_fit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // fit predictor state
  logic signed [63:0] moment_x[7];
  logic signed [63:0] moment_xy[4];
  logic signed [63:0] coef[4];
  logic held_fit;
  logic [15:0] gain;

  out_item_t fits_due[$];
  int errors = 0;
  int items_in = 0;
  int results_seen = 0;
  int solves = 0;
  int singulars = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  task automatic report(input string msg);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, msg);
  endtask

  function automatic logic signed [63:0] sat_val(input bit neg, input logic [127:0] mag);
    if (neg) begin
      if (mag >= 128'h8000_0000_0000_0000) return SMin;
      return -$signed(mag[63:0]);
    end
    if (mag > 128'h7FFF_FFFF_FFFF_FFFF) return SMax;
    return $signed(mag[63:0]);
  endfunction

  function automatic logic [63:0] absv(input logic signed [63:0] v);
    return v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] q_add(input logic signed [63:0] a, b);
    logic signed [64:0] s;
    s = 65'(a) + 65'(b);
    if (s[64] != s[63]) return s[64] ? SMin : SMax;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] q_sub(input logic signed [63:0] a, b);
    logic signed [64:0] s;
    s = 65'(a) - 65'(b);
    if (s[64] != s[63]) return s[64] ? SMin : SMax;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] q_mul(input logic signed [63:0] a, b);
    logic [127:0] p;
    p = 128'(absv(a)) * 128'(absv(b));
    p = (p + 128'd32768) >> 16;
    return sat_val(a[63] != b[63], p);
  endfunction

  // rounds half away from zero on the magnitude; divisor nonzero
  function automatic logic signed [63:0] q_div(input logic signed [63:0] a, b);
    logic [127:0] num, den, q, r;
    num = 128'(absv(a)) << 16;
    den = 128'(absv(b));
    q = num / den;
    r = num % den;
    if (r >= den - r) q = q + 1;
    return sat_val(a[63] != b[63], q);
  endfunction

  function automatic void solve_normal(output bit sing);
    logic signed [63:0] m[4][5];
    logic signed [63:0] t, piv, f;
    logic [63:0] bm;
    int best;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) m[i][j] = moment_x[6-i-j];
      m[i][4] = moment_xy[3-i];
    end
    for (int c = 0; c < 4; c++) begin
      best = c;
      bm = absv(m[c][c]);
      for (int i = c + 1; i < 4; i++) begin
        if (absv(m[i][c]) > bm) begin
          bm = absv(m[i][c]);
          best = i;
        end
      end
      if (bm == 0) begin
        sing = 1'b1;
        for (int k = 0; k < 4; k++) coef[k] = '0;
        held_fit = 1'b0;
        return;
      end
      for (int k = 0; k < 5; k++) begin
        t = m[c][k];
        m[c][k] = m[best][k];
        m[best][k] = t;
      end
      piv = m[c][c];
      for (int k = c; k < 5; k++) m[c][k] = q_div(m[c][k], piv);
      for (int j = 0; j < 4; j++) begin
        if (j != c) begin
          f = m[j][c];
          for (int k = c; k < 5; k++) m[j][k] = q_sub(m[j][k], q_mul(f, m[c][k]));
        end
      end
    end
    for (int i = 0; i < 4; i++) coef[i] = m[i][4];
    sing = 1'b0;
    held_fit = 1'b1;
  endfunction

  // advances the predictor by one item; returns 1 when a result is due
  function automatic bit predict_fit(input in_item_t it, output out_item_t res);
    logic signed [63:0] pw[7];
    logic signed [63:0] ang, prod, y, v;
    bit sing;
    res = '0;
    if (action_t'(it.action) == ACT_CLEAR) begin
      for (int k = 0; k < 7; k++) moment_x[k] = '0;
      for (int k = 0; k < 4; k++) moment_xy[k] = '0;
      return 1'b0;
    end
    if (action_t'(it.action) == ACT_SOLVE) begin
      solve_normal(sing);
      res.singular = sing;
      res.fit_valid = held_fit;
      return 1'b1;
    end
    if (!it.is_inner) return 1'b0;
    pw[0] = 64'sd65536;
    for (int k = 1; k < 7; k++) pw[k] = q_mul(pw[k-1], 64'(it.func_value));
    if (action_t'(it.action) == ACT_LOAD) begin
      ang = 64'(it.ref_angle_deg);
      prod = ang * (64'sd256 + 64'(gain));
      y = (prod > NinetyQ * 256) ? ang : ((prod + 128) >>> 8);
      for (int k = 0; k < 7; k++) moment_x[k] = q_add(moment_x[k], pw[k]);
      for (int k = 0; k < 4; k++) moment_xy[k] = q_add(moment_xy[k], q_mul(pw[k], y));
      return 1'b0;
    end
    v = q_mul(coef[0], pw[3]);
    v = q_add(v, q_mul(coef[1], pw[2]));
    v = q_add(v, q_mul(coef[2], pw[1]));
    v = q_add(v, coef[3]);
    if (v > NinetyQ) v = NinetyQ;
    if (v < 0) v = 0;
    res.result_kind = 1'b1;
    res.angle_out_deg = v[22:0];
    res.fit_valid = held_fit;
    return 1'b1;
  endfunction

  // stimulus table row; typed rows carry their expected result
  typedef struct {
    action_t act;
    logic signed [23:0] x;
    logic [22:0] ang;
    bit inner;
    bit typed;
    out_item_t want;
  } step_t;

  function automatic in_item_t mk(input action_t a, input logic signed [23:0] x,
                                  input logic [22:0] ang, input bit inner);
    in_item_t it;
    it.action = a;
    it.func_value = x;
    it.ref_angle_deg = ang;
    it.is_inner = inner;
    return it;
  endfunction

  task automatic send(input in_item_t it, input bit typed = 1'b0,
                      input out_item_t want = '0);
    out_item_t res;
    int gap;
    gap = (!quiet && $urandom_range(3) == 0) ? $urandom_range(17, 1) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    do @(posedge clk); while (!in_if.ready);
    items_in++;
    if (predict_fit(it, res)) fits_due.insert(fits_due.size(), typed ? want : res);
    @(negedge clk);
  endtask

  // register writes only with the block idle: no result owed, loads drained
  task automatic set_gain(input logic [15:0] g);
    in_if.valid <= 1'b0;
    wait (fits_due.size() == 0);
    @(negedge clk);
    repeat (200) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= g;
    @(negedge clk);
    cfg_we <= 1'b0;
    gain = g;
  endtask

  // result side stall bursts
  initial begin
    int stall;
    stall = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else if (!quiet && $urandom_range(4) == 0) begin
        stall = $urandom_range(17, 1) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("watchdog: no item moved for %0d cycles", WatchLimit);
        $display("cubic_least_squares_angle_fit verification failed");
        $finish;
      end
    end
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (fits_due.size() == 0) begin
        report($sformatf("unexpected result %p", out_if.data));
      end else begin
        want = fits_due.pop_front();
        if (out_if.data.result_kind == 1'b0) begin
          solves++;
          if (out_if.data.singular) singulars++;
        end
        if (out_if.data.result_kind !== want.result_kind)
          report($sformatf("result_kind %0b want %0b", out_if.data.result_kind,
                           want.result_kind));
        if (out_if.data.angle_out_deg !== want.angle_out_deg)
          report($sformatf("angle_out_deg %0d want %0d", out_if.data.angle_out_deg,
                           want.angle_out_deg));
        if (out_if.data.singular !== want.singular)
          report($sformatf("singular %0b want %0b", out_if.data.singular, want.singular));
        if (out_if.data.fit_valid !== want.fit_valid)
          report($sformatf("fit_valid %0b want %0b", out_if.data.fit_valid,
                           want.fit_valid));
      end
    end
  end

  initial begin
    step_t steps[$];
    step_t s;
    out_item_t sol_sing, ev_zero;
    in_item_t it;
    int phase, npts;
    logic signed [23:0] x;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.data = '0;
    for (int k = 0; k < 7; k++) moment_x[k] = '0;
    for (int k = 0; k < 4; k++) moment_xy[k] = '0;
    for (int k = 0; k < 4; k++) coef[k] = '0;
    held_fit = 1'b0;
    gain = 16'd2560;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    sol_sing = '0;
    sol_sing.singular = 1'b1;
    ev_zero = '0;
    ev_zero.result_kind = 1'b1;

    // fresh block: no fit, zero sums
    steps.insert(steps.size(), '{ACT_EVAL, 24'sd0, 23'd0, 1'b1, 1'b1, ev_zero});
    steps.insert(steps.size(), '{ACT_SOLVE, 24'sd0, 23'd0, 1'b1, 1'b1, sol_sing});
    steps.insert(steps.size(), '{ACT_EVAL, 24'sd65536, 23'd0, 1'b0, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_LOAD, 24'sd65536, 23'd5898240, 1'b0, 1'b0, '0});
    // extremes of x and angle, and an angle above 90
    steps.insert(steps.size(), '{ACT_LOAD, 24'sh7FFFFF, 23'd5898240, 1'b1, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_LOAD, 24'sh800000, 23'd0, 1'b1, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_LOAD, 24'sd65536, 23'd5898240, 1'b1, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_LOAD, -24'sd65536, 23'h7FFFFF, 1'b1, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_LOAD, 24'sd131072, 23'd1966080, 1'b1, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_LOAD, 24'sd0, 23'd2949120, 1'b1, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_LOAD, 24'sd196608, 23'd3932160, 1'b1, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_SOLVE, 24'sd0, 23'd0, 1'b1, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_EVAL, 24'sd0, 23'd0, 1'b1, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_EVAL, 24'sh7FFFFF, 23'd0, 1'b1, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_EVAL, 24'sh800000, 23'd0, 1'b1, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_EVAL, 24'sd65536, 23'd0, 1'b1, 1'b0, '0});
    steps.insert(steps.size(), '{ACT_CLEAR, 24'sd0, 23'd0, 1'b1, 1'b0, '0});
    // zero sums after clear give a singular system and drop the fit
    steps.insert(steps.size(), '{ACT_SOLVE, 24'sd0, 23'd0, 1'b0, 1'b1, sol_sing});
    steps.insert(steps.size(), '{ACT_EVAL, 24'sd98304, 23'd0, 1'b1, 1'b1, ev_zero});

    @(negedge clk);
    foreach (steps[i]) begin
      s = steps[i];
      send(mk(s.act, s.x, s.ang, s.inner), s.typed, s.want);
    end

    // random phases: every third one a register setting, then clear/load/solve/evaluate
    phase = 0;
    while (items_in < 420) begin
      if (items_in > 360) quiet = 1'b1;
      if (phase % 3 == 0) begin
        case (phase / 3)
          0: set_gain(16'd0);
          1: set_gain(16'hFFFF);
          2: set_gain(16'd2560);
          default: set_gain(16'($urandom_range(65535)));
        endcase
        @(negedge clk);
      end
      send(mk(ACT_CLEAR, 24'($urandom), 23'($urandom), 1'($urandom)));
      npts = $urandom_range(8, 3);
      for (int p = 0; p < npts; p++) begin
        if ($urandom_range(9) == 0) x = 24'($urandom);
        else x = 24'($signed($urandom_range(524288)) - 262144);
        send(mk(ACT_LOAD, x, 23'($urandom_range(5898240)), 1'b1));
        if ($urandom_range(6) == 0) begin
          it = in_item_t'(50'({$urandom, $urandom}));
          if (action_t'(it.action) == ACT_CLEAR) it.is_inner = 1'b0;
          if (action_t'(it.action) == ACT_CLEAR) it.action = ACT_LOAD;
          send(it);
        end
      end
      send(mk(ACT_SOLVE, 24'($urandom), 23'($urandom), 1'($urandom)));
      repeat ($urandom_range(5, 2)) begin
        if ($urandom_range(4) == 0) x = 24'($urandom);
        else x = 24'($signed($urandom_range(524288)) - 262144);
        send(mk(ACT_EVAL, x, 23'($urandom), $urandom_range(7) != 0));
      end
      phase++;
    end

    in_if.valid <= 1'b0;
    wait (fits_due.size() == 0);
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d items, %0d results, %0d solves (%0d singular), %0d phases",
             items_in, results_seen, solves, singulars, phase);
    if (errors == 0 && fits_due.size() == 0) begin
      $display("cubic_least_squares_angle_fit verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, fits_due.size());
      $display("cubic_least_squares_angle_fit verification failed");
    end
    $finish;
  end

endmodule
